// ----- rtl/vna_pkg.sv -----
// shared types, constants and helpers of the vertex normal accumulator
package vna_pkg;

    localparam int COORD_W = 16;
    localparam int IDX_W   = 10;
    localparam int CR_W    = 36;
    localparam int NRM_W   = 16;
    localparam int ACC_W   = 24;
    localparam int Q14_ONE = 16384;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_TRI   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [CR_W-1:0]    t_cr;
    typedef logic signed [NRM_W-1:0]   t_nrm;

    typedef struct packed {
        logic done;
        logic degen;
    } t_norm_stat;

    // operand lanes of the k-th cross product term: {edge ab lane, edge ac lane}
    function automatic logic [3:0] cross_ops(input logic [2:0] k);
        logic [3:0] ops;
        case (k)
            3'd0:    ops = {2'd1, 2'd2};
            3'd1:    ops = {2'd2, 2'd1};
            3'd2:    ops = {2'd2, 2'd0};
            3'd3:    ops = {2'd0, 2'd2};
            3'd4:    ops = {2'd0, 2'd1};
            3'd5:    ops = {2'd1, 2'd0};
            default: ops = {2'd0, 2'd0};
        endcase
        return ops;
    endfunction

endpackage

// ----- rtl/vertex_normal_accumulator.sv -----
// top level of the vertex normal accumulator: memories, sequencer and result register
//
// usage: one command per input beat on the slave stream. tuser carries the
// command (write vertex, add triangle, read vertex normal); tdata carries the
// vertex index, the q8.8 coordinates and the three triangle corners. every
// command returns exactly one beat on the master stream: a q1.14 unit normal
// in tdata (zero except for reads) and the degenerate flag in tuser.
// items are handled one at a time. a write, an unused command or a triangle
// with a corner out of range goes straight to the output beat. a read
// normalises the stored accumulator, and a triangle normalises its face and
// adds it to its corners; tready returns as the output beat appears.
// the normaliser runs its shift loop, its 32-step square root and its
// 15-step division, and skips them for a zero vector; a triangle adds three
// vertex reads, a cross product on one multiplier and three
// read-modify-write passes on the accumulator memory.
// after reset the accumulator memory is cleared, one entry a cycle, and
// tready stays low meanwhile. vertex positions are not
// cleared and must be written before a triangle uses them.
// a stalled receiver holds the finished beat in the output register; the
// next command is still taken and waits at its end for the register to free.
module vertex_normal_accumulator #(
    parameter int MAX_VERTICES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // vertex_index, coord_x, coord_y, coord_z, corner_a, corner_b, corner_c
    input  logic [87:0] i_s_tdata,
    // command
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // normal_x, normal_y, normal_z
    output logic [47:0] o_m_tdata,
    // degenerate
    output logic        o_m_tuser
);
    import vna_pkg::*;

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

    typedef enum logic [10:0] {
        S_CLR   = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_RDB   = 11'b00000000100,
        S_RDC   = 11'b00000001000,
        S_LATC  = 11'b00000010000,
        S_CROSS = 11'b00000100000,
        S_NORM  = 11'b00001000000,
        S_ACCRD = 11'b00010000000,
        S_ACCWR = 11'b00100000000,
        S_RDACC = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } t_state;

    // memories
    logic [3*COORD_W-1:0] vmem [MAX_VERTICES];
    logic [3*ACC_W-1:0]   amem [MAX_VERTICES];
    logic [3*COORD_W-1:0] r_vrd;
    logic [3*ACC_W-1:0]   r_ard;

    // control and payload registers
    t_state             r_state;
    logic [AW-1:0]      r_clr;
    t_cmd               r_cmd;
    logic [IDX_W-1:0]   r_ca, r_cb, r_cc;
    logic               r_vin;
    t_coord             r_va [3];
    t_coord             r_vb [3];
    t_nrm               r_face [3];
    logic               r_fdeg;
    logic [1:0]         r_ci;
    t_nrm               r_res_n [3];
    logic               r_res_deg;
    logic               r_ovalid;
    logic [47:0]        r_odata;
    logic               r_ouser;

    // input beat fields
    t_cmd               in_cmd;
    logic [IDX_W-1:0]   in_vi, in_ca, in_cb, in_cc;
    logic               accept;
    logic               vi_ok, tri_ok;

    // memory ports
    logic               v_we;
    logic [AW-1:0]      v_raddr;
    logic [AW-1:0]      a_raddr;
    logic               a_we;
    logic [AW-1:0]      a_waddr;
    logic [3*ACC_W-1:0] a_wdata;
    logic [IDX_W-1:0]   corner;
    logic [ACC_W-1:0]   acc_new [3];

    // datapath units
    t_coord             vc [3];
    logic               cross_start;
    t_cr                cross_cr [3];
    logic               cross_done;
    logic               norm_start;
    t_cr                norm_v [3];
    t_nrm               norm_n [3];
    t_norm_stat         norm_stat;

    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                 input t_nrm b);
        logic signed [ACC_W:0] s;
        s = $signed({a[ACC_W-1], a}) + (ACC_W+1)'(b);
        if (s[ACC_W] != s[ACC_W-1]) begin
            return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        return s[ACC_W-1:0];
    endfunction

    assign in_cmd = t_cmd'(i_s_tuser);
    assign in_vi  = i_s_tdata[9:0];
    assign in_ca  = i_s_tdata[67:58];
    assign in_cb  = i_s_tdata[77:68];
    assign in_cc  = i_s_tdata[87:78];

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;

    assign vi_ok  = (32'(in_vi) < 32'(MAX_VERTICES));
    assign tri_ok = (32'(in_ca) < 32'(MAX_VERTICES)) && (32'(in_cb) < 32'(MAX_VERTICES))
                 && (32'(in_cc) < 32'(MAX_VERTICES));

    always_comb begin
        v_we = accept && (in_cmd == CMD_WRITE) && vi_ok;
        unique case (r_state)
            S_IDLE:  v_raddr = AW'(in_ca);
            S_RDB:   v_raddr = AW'(r_cb);
            default: v_raddr = AW'(r_cc);
        endcase

        case (r_ci)
            2'd0:    corner = r_ca;
            2'd1:    corner = r_cb;
            default: corner = r_cc;
        endcase

        a_raddr = (r_state == S_IDLE) ? AW'(in_vi) : AW'(corner);

        for (int i = 0; i < 3; i++) begin
            acc_new[i] = sat_add(r_ard[i*ACC_W +: ACC_W], r_face[i]);
        end
        a_we    = (r_state == S_CLR) || (r_state == S_ACCWR);
        a_waddr = (r_state == S_CLR) ? r_clr : AW'(corner);
        a_wdata = (r_state == S_CLR) ? '0 : {acc_new[2], acc_new[1], acc_new[0]};

        // third corner comes straight from the vertex read register
        for (int i = 0; i < 3; i++) begin
            vc[i] = r_vrd[i*COORD_W +: COORD_W];
        end
        cross_start = (r_state == S_LATC);

        // the normaliser takes either the face normal or a stored accumulator
        for (int i = 0; i < 3; i++) begin
            if (r_state == S_RDACC) begin
                norm_v[i] = r_vin ? CR_W'($signed(r_ard[i*ACC_W +: ACC_W])) : '0;
            end else begin
                norm_v[i] = cross_cr[i];
            end
        end
        norm_start = (r_state == S_RDACC) || ((r_state == S_CROSS) && cross_done);
    end

    // vertex store: one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (v_we) begin
            vmem[AW'(in_vi)] <= i_s_tdata[57:10];
        end
        r_vrd <= vmem[v_raddr];
    end

    // accumulator store, read-modify-write one corner at a time
    always_ff @(posedge i_clk) begin
        if (a_we) begin
            amem[a_waddr] <= a_wdata;
        end
        r_ard <= amem[a_raddr];
    end

    vna_cross u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cross_start),
        .i_a     (r_va),
        .i_b     (r_vb),
        .i_c     (vc),
        .o_cr    (cross_cr),
        .o_done  (cross_done)
    );

    vna_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (norm_start),
        .i_v     (norm_v),
        .o_n     (norm_n),
        .o_stat  (norm_stat)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            r_ci     <= '0;
        end else begin
            if (r_ovalid && i_m_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(MAX_VERTICES - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (accept) begin
                        r_cmd     <= in_cmd;
                        r_ca      <= in_ca;
                        r_cb      <= in_cb;
                        r_cc      <= in_cc;
                        r_vin     <= vi_ok;
                        r_ci      <= '0;
                        r_res_deg <= 1'b0;
                        for (int i = 0; i < 3; i++) r_res_n[i] <= '0;
                        case (in_cmd)
                            CMD_TRI:  r_state <= tri_ok ? S_RDB : S_DONE;
                            CMD_READ: r_state <= S_RDACC;
                            default:  r_state <= S_DONE;
                        endcase
                    end
                end
                S_RDB: begin
                    for (int i = 0; i < 3; i++) r_va[i] <= r_vrd[i*COORD_W +: COORD_W];
                    r_state <= S_RDC;
                end
                S_RDC: begin
                    for (int i = 0; i < 3; i++) r_vb[i] <= r_vrd[i*COORD_W +: COORD_W];
                    r_state <= S_LATC;
                end
                S_LATC: begin
                    r_state <= S_CROSS;
                end
                S_CROSS: begin
                    if (cross_done) r_state <= S_NORM;
                end
                S_RDACC: begin
                    r_state <= S_NORM;
                end
                S_NORM: begin
                    if (norm_stat.done) begin
                        if (r_cmd == CMD_TRI) begin
                            r_face  <= norm_n;
                            r_fdeg  <= norm_stat.degen;
                            r_ci    <= '0;
                            r_state <= S_ACCRD;
                        end else begin
                            r_res_n   <= norm_n;
                            r_res_deg <= norm_stat.degen;
                            r_state   <= S_DONE;
                        end
                    end
                end
                S_ACCRD: begin
                    r_state <= S_ACCWR;
                end
                S_ACCWR: begin
                    r_ci <= r_ci + 2'd1;
                    if (r_ci == 2'd2) begin
                        r_res_deg <= r_fdeg;
                        r_state   <= S_DONE;
                    end else begin
                        r_state   <= S_ACCRD;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || i_m_tready) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {r_res_n[2], r_res_n[1], r_res_n[0]};
                        r_ouser  <= r_res_deg;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ouser;

endmodule

// ----- rtl/vna_cross.sv -----
// cross product of the two triangle edges over one shared multiplier
module vna_cross (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  vna_pkg::t_coord i_a [3],
    input  vna_pkg::t_coord i_b [3],
    input  vna_pkg::t_coord i_c [3],
    output vna_pkg::t_cr   o_cr [3],
    output logic           o_done
);
    import vna_pkg::*;

    logic signed [COORD_W:0]     r_ab [3];
    logic signed [COORD_W:0]     r_ac [3];
    logic signed [2*COORD_W+1:0] r_prod;
    t_cr                         r_cr [3];
    logic [2:0]                  r_k;
    logic                        r_busy;
    logic                        r_done;

    logic [3:0] ops;
    logic [2:0] km1;
    logic [1:0] lane;

    assign ops  = cross_ops(r_k);
    assign km1  = r_k - 3'd1;
    assign lane = km1[2:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                for (int i = 0; i < 3; i++) begin
                    r_ab[i] <= {i_b[i][COORD_W-1], i_b[i]} - {i_a[i][COORD_W-1], i_a[i]};
                    r_ac[i] <= {i_c[i][COORD_W-1], i_c[i]} - {i_a[i][COORD_W-1], i_a[i]};
                    r_cr[i] <= '0;
                end
                r_k    <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_k != 3'd6) begin
                    r_prod <= r_ab[ops[3:2]] * r_ac[ops[1:0]];
                end
                // odd steps add the first term of a lane, even steps subtract the second
                if (r_k != 3'd0) begin
                    if (r_k[0]) begin
                        r_cr[lane] <= r_cr[lane] + CR_W'(r_prod);
                    end else begin
                        r_cr[lane] <= r_cr[lane] - CR_W'(r_prod);
                    end
                end
                r_k <= r_k + 3'd1;
                if (r_k == 3'd6) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_cr   = r_cr;
    assign o_done = r_done;

endmodule

// ----- rtl/vna_norm.sv -----
// iterative scaling of a vector to unit length in q1.14
module vna_norm (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  vna_pkg::t_cr        i_v [3],
    output vna_pkg::t_nrm       o_n [3],
    output vna_pkg::t_norm_stat o_stat
);
    import vna_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SHIFT = 7'b0000010,
        S_SQ    = 7'b0000100,
        S_ROOT  = 7'b0001000,
        S_DSET  = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    localparam logic [CR_W-1:0] MAG_HI = CR_W'(64'h4000_0000);
    localparam logic [CR_W-1:0] MAG_LO = CR_W'(64'h2000_0000);

    t_state          r_state;
    logic [CR_W-1:0] r_mag [3];
    logic [2:0]      r_sign;
    logic [CR_W-1:0] r_mx;
    logic [3:0]      r_cnt;
    logic [59:0]     r_prod;
    logic [61:0]     r_sum;
    logic [61:0]     r_x;
    logic [62:0]     r_bit;
    logic [62:0]     r_res;
    logic [45:0]     r_rem [3];
    logic [44:0]     r_d;
    logic [14:0]     r_q [3];
    t_nrm            r_n [3];
    t_norm_stat      r_stat;

    logic [CR_W-1:0] in_mag [3];
    logic [CR_W-1:0] in_mx;
    logic [29:0]     sq_op;
    logic [59:0]     sq;
    logic [63:0]     trial;
    logic [30:0]     len;
    logic [14:0]     qc [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_mag[i] = i_v[i][CR_W-1] ? CR_W'(-i_v[i]) : CR_W'(i_v[i]);
        end
        in_mx = in_mag[0];
        if (in_mag[1] > in_mx) in_mx = in_mag[1];
        if (in_mag[2] > in_mx) in_mx = in_mag[2];
        sq_op = r_mag[r_cnt[1:0]][29:0];
        sq    = sq_op * sq_op;
        trial = {1'b0, r_res} + {1'b0, r_bit};
        len   = r_res[30:0];
        for (int i = 0; i < 3; i++) begin
            qc[i] = (r_q[i] > 15'(Q14_ONE)) ? 15'(Q14_ONE) : r_q[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stat  <= '0;
            r_cnt   <= '0;
        end else begin
            r_stat.done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        for (int i = 0; i < 3; i++) begin
                            r_mag[i]  <= in_mag[i];
                            r_sign[i] <= i_v[i][CR_W-1];
                        end
                        r_mx <= in_mx;
                        if (in_mx == '0) begin
                            for (int i = 0; i < 3; i++) r_n[i] <= '0;
                            r_stat <= '{done: 1'b1, degen: 1'b1};
                        end else begin
                            r_state <= S_SHIFT;
                        end
                    end
                end
                S_SHIFT: begin
                    // bring the largest magnitude into [2^29, 2^30)
                    if (r_mx >= MAG_HI) begin
                        for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] >> 1;
                        r_mx <= r_mx >> 1;
                    end else if (r_mx < MAG_LO) begin
                        for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] << 1;
                        r_mx <= r_mx << 1;
                    end else begin
                        r_cnt   <= '0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (r_cnt != 4'd3) r_prod <= sq;
                    if (r_cnt == 4'd0) begin
                        r_sum <= '0;
                    end else begin
                        r_sum <= r_sum + 62'(r_prod);
                    end
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd3) begin
                        r_x     <= r_sum + 62'(r_prod);
                        r_bit   <= 63'd1 << 62;
                        r_res   <= '0;
                        r_state <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    if ({2'b00, r_x} >= trial) begin
                        r_x   <= r_x - 62'(trial);
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit == 63'd1) r_state <= S_DSET;
                end
                S_DSET: begin
                    for (int i = 0; i < 3; i++) begin
                        r_rem[i] <= {r_mag[i][29:0], 14'b0} + 46'(len >> 1);
                        r_q[i]   <= '0;
                    end
                    r_d     <= {len, 14'b0};
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // restoring division, one quotient bit per lane each cycle
                    for (int i = 0; i < 3; i++) begin
                        if (r_rem[i] >= 46'(r_d)) begin
                            r_rem[i] <= r_rem[i] - 46'(r_d);
                            r_q[i]   <= {r_q[i][13:0], 1'b1};
                        end else begin
                            r_q[i]   <= {r_q[i][13:0], 1'b0};
                        end
                    end
                    r_d   <= r_d >> 1;
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd14) r_state <= S_DONE;
                end
                S_DONE: begin
                    for (int i = 0; i < 3; i++) begin
                        r_n[i] <= r_sign[i] ? -NRM_W'(qc[i]) : NRM_W'(qc[i]);
                    end
                    r_stat  <= '{done: 1'b1, degen: 1'b0};
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_n    = r_n;
    assign o_stat = r_stat;

endmodule

// ----- tb/sv/tb_vertex_normal_accumulator.sv -----
// self-checking testbench of the vertex normal accumulator
`timescale 1ns / 1ps

module tb_vertex_normal_accumulator;
    import vna_pkg::*;

    localparam int NVERT     = 1024;
    localparam int N_RANDOM  = 700;
    localparam int CYCLE_CAP = 1000000;
    localparam int ACC_HI    = 8388607;
    localparam int ACC_LO    = -8388608;

    typedef struct packed {
        t_cmd             cmd;
        logic [IDX_W-1:0] vidx;
        t_coord           cx;
        t_coord           cy;
        t_coord           cz;
        logic [IDX_W-1:0] ca;
        logic [IDX_W-1:0] cb;
        logic [IDX_W-1:0] cc;
    } t_item;

    localparam int ITEM_W = $bits(t_item);

    typedef struct packed {
        t_nrm nx;
        t_nrm ny;
        t_nrm nz;
        logic degen;
    } t_normal_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [87:0] i_s_tdata = '0;
    logic [1:0]  i_s_tuser = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [47:0] o_m_tdata;
    logic        o_m_tuser;

    vertex_normal_accumulator u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser)
    );

    // predictor state
    logic signed [31:0] pos[NVERT][3];
    bit                 pos_written[NVERT];
    int                 acc_x[NVERT], acc_y[NVERT], acc_z[NVERT];

    t_item        pending_cmds[$];
    t_normal_beat expected_normals[$];
    int           n_errors = 0;
    bit           stim_done = 0;
    int           n_sent = 0;
    int           hold_at = 1000000;
    int           calm_at = 1000000;
    logic         calm;            // no idling in the last part
    logic         hold_off_req;
    int           cycle_count = 0;

    assign calm         = (n_sent >= calm_at);
    assign hold_off_req = (n_sent >= hold_at);

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint unsigned root64(longint unsigned x);
        longint unsigned res = 0;
        longint unsigned bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // scale a vector to unit length in q1.14; returns 1 on zero length
    function automatic bit to_unit(input longint v[3], output int n[3]);
        longint unsigned mag[3];
        longint unsigned mx = 0, sum = 0, len, q;
        int up = 0, down = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = v[i] < 0 ? longint'(0) - v[i] : v[i];
            if (mag[i] > mx) mx = mag[i];
        end
        if (mx == 0) begin
            n[0] = 0; n[1] = 0; n[2] = 0;
            return 1;
        end
        while (mx >= (64'd1 << 30)) begin mx >>= 1; down++; end
        while (mx < (64'd1 << 29)) begin mx <<= 1; up++; end
        for (int i = 0; i < 3; i++) begin
            mag[i] = (mag[i] >> down) << up;
            sum += mag[i] * mag[i];
        end
        len = root64(sum);
        for (int i = 0; i < 3; i++) begin
            q = (mag[i] * Q14_ONE + len / 2) / len;
            if (q > Q14_ONE) q = Q14_ONE;
            n[i] = v[i] < 0 ? -int'(q) : int'(q);
        end
        return 0;
    endfunction

    function automatic int sat_acc(int a, int b);
        longint s = longint'(a) + b;
        if (s > ACC_HI) return ACC_HI;
        if (s < ACC_LO) return ACC_LO;
        return int'(s);
    endfunction

    // expected result beat of one command, updating the predictor state
    function automatic t_normal_beat predict_normal(t_item it);
        t_normal_beat r = '0;
        longint ab[3], ac[3], cr[3], av[3];
        int face[3], nrm[3];
        int k;
        int corners[3];
        case (it.cmd)
            CMD_WRITE: begin
                pos[it.vidx][0] = 32'(it.cx);
                pos[it.vidx][1] = 32'(it.cy);
                pos[it.vidx][2] = 32'(it.cz);
            end
            CMD_TRI: begin
                for (int i = 0; i < 3; i++) begin
                    ab[i] = longint'(pos[it.cb][i]) - longint'(pos[it.ca][i]);
                    ac[i] = longint'(pos[it.cc][i]) - longint'(pos[it.ca][i]);
                end
                cr[0] = ab[1] * ac[2] - ab[2] * ac[1];
                cr[1] = ab[2] * ac[0] - ab[0] * ac[2];
                cr[2] = ab[0] * ac[1] - ab[1] * ac[0];
                r.degen = to_unit(cr, face);
                corners[0] = int'(it.ca); corners[1] = int'(it.cb); corners[2] = int'(it.cc);
                for (int i = 0; i < 3; i++) begin
                    k = corners[i];
                    acc_x[k] = sat_acc(acc_x[k], face[0]);
                    acc_y[k] = sat_acc(acc_y[k], face[1]);
                    acc_z[k] = sat_acc(acc_z[k], face[2]);
                end
            end
            CMD_READ: begin
                av[0] = longint'(acc_x[it.vidx]);
                av[1] = longint'(acc_y[it.vidx]);
                av[2] = longint'(acc_z[it.vidx]);
                r.degen = to_unit(av, nrm);
                r.nx = NRM_W'(nrm[0]); r.ny = NRM_W'(nrm[1]); r.nz = NRM_W'(nrm[2]);
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] any_written();
        int v;
        do v = $urandom_range(NVERT - 1); while (!pos_written[v]);
        return IDX_W'(v);
    endfunction

    // queue a command; writes mark vertices usable by later triangles
    task automatic push_cmd(t_item it);
        if (it.cmd == CMD_WRITE) pos_written[it.vidx] = 1;
        pending_cmds = {pending_cmds, it};
    endtask

    task automatic push_write(int v, int x, int y, int z);
        t_item it = '0;
        it.cmd = CMD_WRITE; it.vidx = IDX_W'(v);
        it.cx = COORD_W'(x); it.cy = COORD_W'(y); it.cz = COORD_W'(z);
        it.ca = IDX_W'($urandom); it.cb = IDX_W'($urandom); it.cc = IDX_W'($urandom);
        push_cmd(it);
    endtask

    task automatic push_tri(int a, int b, int c);
        t_item it;
        it = ITEM_W'({$urandom, $urandom, $urandom});
        it.cmd = CMD_TRI; it.ca = IDX_W'(a); it.cb = IDX_W'(b); it.cc = IDX_W'(c);
        push_cmd(it);
    endtask

    task automatic push_read(int v);
        t_item it;
        it = ITEM_W'({$urandom, $urandom, $urandom});
        it.cmd = CMD_READ; it.vidx = IDX_W'(v);
        push_cmd(it);
    endtask

    // stimulus
    initial begin
        t_item it;
        int sel;
        // directed: extremes, degenerate faces, repeated corners, saturation
        push_read(0);                                   // untouched accumulator
        push_write(0, 0, 0, 0);
        push_write(1, 32767, 0, 0);
        push_write(2, 0, 32767, 0);
        push_write(3, -32768, -32768, -32768);
        push_write(1023, 32767, 32767, 32767);
        push_tri(0, 1, 2);
        push_read(0);
        push_tri(0, 0, 0);                              // zero-length face
        push_tri(0, 1, 1);                              // repeated corner
        push_tri(3, 1023, 2);
        push_tri(3, 1, 1023);
        push_read(1023);
        push_read(3);
        push_write(4, 1, 0, 0);
        push_write(5, 0, 1, 0);
        push_tri(0, 4, 5);                              // smallest face
        push_read(4);
        it = '0; it.cmd = CMD_NONE; it.vidx = '1; it.cx = '1; it.cy = '1; it.cz = '1;
        it.ca = '1; it.cb = '1; it.cc = '1;
        push_cmd(it);                                   // unused command
        // drive three accumulators into saturation
        for (int i = 0; i < 4; i++) push_tri(0, 0, 1);
        for (int i = 0; i < 520; i++) push_tri(0, 1, 2);
        push_read(0);
        push_read(2);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 3) hold_at = pending_cmds.size();
            if (n == N_RANDOM * 4 / 5) calm_at = pending_cmds.size();
            // saturation pressure: bursts of one triangle repeated
            if (n % 200 == 100) begin
                for (int i = 0; i < 12; i++) push_tri(1, 2, 0);
                push_read($urandom_range(2));
            end
            sel = $urandom_range(99);
            if (sel < 25) begin
                if ($urandom_range(3) == 0)
                    push_write($urandom_range(NVERT - 1), $urandom, $urandom, $urandom);
                else
                    push_write($urandom_range(63), $urandom_range(2047) - 1024,
                               $urandom_range(2047) - 1024, $urandom_range(2047) - 1024);
            end else if (sel < 65) begin
                push_tri(any_written(), any_written(), any_written());
            end else if (sel < 95) begin
                push_read($urandom_range(3) == 0 ? $urandom_range(NVERT - 1)
                                                 : $urandom_range(63));
            end else begin
                it = ITEM_W'({$urandom, $urandom, $urandom});
                it.cmd = CMD_NONE;
                push_cmd(it);
            end
        end
        stim_done = 1;
    end

    // reset, once
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // driver
    int   src_gap = 0;
    t_item cur_item;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                expected_normals = {expected_normals, predict_normal(cur_item)};
                n_sent <= n_sent + 1;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    i_s_tvalid <= 1'b0;
                end else if (!calm && $urandom_range(9) == 0) begin
                    src_gap <= $urandom_range(17) - 1;
                    i_s_tvalid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    cur_item = pending_cmds.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tuser  <= cur_item.cmd;
                    // tdata from the lowest bit: vertex_index, coords, corners
                    i_s_tdata  <= {cur_item.cc, cur_item.cb, cur_item.ca, cur_item.cz,
                                   cur_item.cy, cur_item.cx, cur_item.vidx};
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // length of the long receiver hold-off, counted in cycles
    int  hold_cnt = 0;
    bit  hold_done = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && hold_off_req && !hold_done) begin
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt == 600) hold_done <= 1'b1;
        end
    end

    // monitor with random back-pressure and one long hold-off
    int  sink_gap = 0;
    t_normal_beat got, want;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                got.nx = o_m_tdata[15:0];
                got.ny = o_m_tdata[31:16];
                got.nz = o_m_tdata[47:32];
                got.degen = o_m_tuser;
                if (expected_normals.size() == 0) begin
                    $display("%0t: unexpected beat, actual %h", $time, got);
                    n_errors++;
                end else begin
                    want = expected_normals.pop_front();
                    if (got.nx !== want.nx)
                        $display("%0t: normal_x expected %0d actual %0d", $time,
                                 want.nx, got.nx);
                    if (got.ny !== want.ny)
                        $display("%0t: normal_y expected %0d actual %0d", $time,
                                 want.ny, got.ny);
                    if (got.nz !== want.nz)
                        $display("%0t: normal_z expected %0d actual %0d", $time,
                                 want.nz, got.nz);
                    if (got.degen !== want.degen)
                        $display("%0t: degenerate expected %0b actual %0b", $time,
                                 want.degen, got.degen);
                    if (got !== want) n_errors++;
                end
            end
            if (hold_off_req && !hold_done) begin
                // long stall so the input side backs up
                i_m_tready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                i_m_tready <= 1'b0;
            end else if (!calm && $urandom_range(9) == 0) begin
                sink_gap <= $urandom_range(17) - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // end of run and watchdog
    initial begin
        fork
            begin
                wait (stim_done && pending_cmds.size() == 0);
                @(posedge i_clk);
                wait (!i_s_tvalid && expected_normals.size() == 0);
                repeat (200) @(posedge i_clk);
                if (n_errors == 0 && expected_normals.size() == 0)
                    $display("PASSED: all results match");
                else
                    $display("FAILED: results differ");
            end
            begin
                while (cycle_count < CYCLE_CAP) begin
                    @(posedge i_clk);
                    cycle_count++;
                end
                $display("FAILED: results differ");
            end
        join_any
        $finish;
    end

endmodule

// ----- vertex_normal_accumulator.f -----
rtl/vna_pkg.sv
rtl/vna_cross.sv
rtl/vna_norm.sv
rtl/vertex_normal_accumulator.sv
tb/sv/tb_vertex_normal_accumulator.sv
